@@ design/mld_pkg.sv @@
// mld_pkg: shared types, constants and the morse symbol table for the light decoder
// no dependencies
package mld_pkg;

	// widths of the register and payload fields
	localparam int unsigned THRESH_W     = 16;
	localparam int unsigned LEN_W        = 24;
	localparam int unsigned PAT_W        = 5;
	localparam int unsigned SLEN_W       = 3;
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned CODE_W       = 7;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 24;
	localparam int unsigned MAX_MARKS    = 5;
	localparam int unsigned STOCK_N      = 36;
	localparam int unsigned DIGIT_BASE   = 26;
	localparam int unsigned ENTRY_W      = 6;
	localparam int unsigned RUN_COUNT_WIDTH_DEF = 24;

	// result queue sizing: two in-flight requests of up to two results each
	localparam int unsigned FIFO_DEPTH   = 4;
	localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_LVL_W   = $clog2(FIFO_DEPTH + 1);

	localparam logic [CODE_W-1:0] ASCII_LOWER_A = 7'd97;
	localparam logic [CODE_W-1:0] ASCII_ZERO    = 7'd48;

	// register reset values
	localparam logic [THRESH_W-1:0] THRESH_RST = 16'd100;
	localparam logic [LEN_W-1:0]    LONG_RST   = 24'd1000;
	localparam logic [LEN_W-1:0]    LETTER_RST = 24'd2000;
	localparam logic [LEN_W-1:0]    WORD_RST   = 24'd3000;
	localparam logic [PAT_W-1:0]    PAT_RST    = 5'd0;
	localparam logic [SLEN_W-1:0]   SLEN_RST   = 3'd5;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MARK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_PAT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_LEN = 3'd5;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_WRONG   = 2'd1,
		KIND_NEWLINE = 2'd2,
		KIND_SPACE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [THRESH_W-1:0] light_threshold;
		logic [LEN_W-1:0]    long_mark_len;
		logic [LEN_W-1:0]    letter_gap_len;
		logic [LEN_W-1:0]    word_gap_len;
		logic [PAT_W-1:0]    special_pattern;
		logic [SLEN_W-1:0]   special_length;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
		logic              last;
	} res_t;

	// up to two results written into the queue in one cycle
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	typedef struct packed {
		logic               hit;
		logic [ENTRY_W-1:0] idx;
	} match_t;

	// marks per entry, bit i is mark i, 1 for long
	localparam logic [PAT_W-1:0] STOCK_BITS [STOCK_N] = '{
		5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
		5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
		5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
		5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011,
		5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000, 5'b00001,
		5'b00011, 5'b00111, 5'b01111
	};

	localparam logic [SLEN_W-1:0] STOCK_LEN [STOCK_N] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	// exact match of the collected marks against the stock table, lowest entry wins
	function automatic match_t stock_lookup(logic [SLEN_W-1:0] cnt, logic [PAT_W-1:0] bits);
		match_t m;
		m.hit = 1'b0;
		m.idx = '0;
		for (int j = STOCK_N - 1; j >= 0; j--) begin
			if (STOCK_LEN[j] == cnt && STOCK_BITS[j] == bits) begin
				m.hit = 1'b1;
				m.idx = ENTRY_W'(j);
			end
		end
		return m;
	endfunction

endpackage

@@ design/mld_cfg_regs.sv @@
// mld_cfg_regs: configuration register file of the light decoder
// depends on mld_pkg
module mld_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mld_pkg::CFG_DATA_W-1:0] cfg_data,
	output mld_pkg::cfg_t                  cfg
);
	import mld_pkg::*;

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes, data truncated to the field width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_threshold <= THRESH_RST;
			cfg_q.long_mark_len   <= LONG_RST;
			cfg_q.letter_gap_len  <= LETTER_RST;
			cfg_q.word_gap_len    <= WORD_RST;
			cfg_q.special_pattern <= PAT_RST;
			cfg_q.special_length  <= SLEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD:   cfg_q.light_threshold <= cfg_data[THRESH_W-1:0];
				REG_LONG_MARK:   cfg_q.long_mark_len   <= cfg_data[LEN_W-1:0];
				REG_LETTER_GAP:  cfg_q.letter_gap_len  <= cfg_data[LEN_W-1:0];
				REG_WORD_GAP:    cfg_q.word_gap_len    <= cfg_data[LEN_W-1:0];
				REG_SPECIAL_PAT: cfg_q.special_pattern <= cfg_data[PAT_W-1:0];
				REG_SPECIAL_LEN: cfg_q.special_length  <= cfg_data[SLEN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ design/mld_decode.sv @@
// mld_decode: input register, run-length tracking, mark collection and letter match
// depends on mld_pkg
module mld_decode #(
	parameter int unsigned RUN_COUNT_WIDTH = mld_pkg::RUN_COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [mld_pkg::SAMPLE_W-1:0] sample,
	input  mld_pkg::cfg_t                cfg,
	output logic                         busy,
	output mld_pkg::push_t               push
);
	import mld_pkg::*;

	localparam int unsigned CMP_W = (RUN_COUNT_WIDTH > LEN_W) ? RUN_COUNT_WIDTH : LEN_W;
	localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = '1;
	localparam logic [SLEN_W-1:0] MARKS_MAX = SLEN_W'(MAX_MARKS);

	logic [SAMPLE_W-1:0]        sample_s1;
	logic                       valid_s1;
	logic                       run_level_q, run_level_d;
	logic [RUN_COUNT_WIDTH-1:0] run_len_q, run_len_d;
	logic [PAT_W-1:0]           mark_bits_q, mark_bits_d;
	logic [SLEN_W-1:0]          mark_count_q, mark_count_d;
	logic                       mark_ovf_q, mark_ovf_d;
	logic                       first_fail_q, first_fail_d;

	logic                       level;
	logic [CMP_W-1:0]           run_ext;
	logic                       is_long, word_end, letter_end;
	match_t                     stock;
	logic [PAT_W-1:0]           spec_mask;
	logic                       spec_hit;
	res_t                       letter_res;
	logic                       letter_emit;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	assign busy = valid_s1;

	// thresholds and run-length compares
	always_comb begin
		level      = sample_s1 > cfg.light_threshold;
		run_ext    = CMP_W'(run_len_q);
		is_long    = run_ext > CMP_W'(cfg.long_mark_len);
		word_end   = run_ext > CMP_W'(cfg.word_gap_len);
		letter_end = word_end || (run_ext > CMP_W'(cfg.letter_gap_len));
	end

	// letter match: stock table first, then the configurable newline entry
	always_comb begin
		stock     = stock_lookup(mark_count_q, mark_bits_q);
		spec_mask = PAT_W'((6'd1 << mark_count_q) - 6'd1);
		spec_hit  = (cfg.special_length == mark_count_q) &&
			((cfg.special_pattern & spec_mask) == (mark_bits_q & spec_mask));
		letter_res.last = !word_end;
		letter_res.code = '0;
		letter_emit     = 1'b1;
		if (!mark_ovf_q && stock.hit) begin
			letter_res.kind = KIND_CHAR;
			if (stock.idx < ENTRY_W'(DIGIT_BASE)) begin
				letter_res.code = CODE_W'(ASCII_LOWER_A + CODE_W'(stock.idx));
			end else begin
				letter_res.code = CODE_W'(ASCII_ZERO + CODE_W'(stock.idx - ENTRY_W'(DIGIT_BASE)));
			end
		end else if (!mark_ovf_q && spec_hit) begin
			letter_res.kind = KIND_NEWLINE;
		end else begin
			letter_res.kind = KIND_WRONG;
			// the first failed letter after reset is swallowed
			letter_emit     = !first_fail_q;
		end
	end

	// state update and result request
	always_comb begin
		run_level_d  = run_level_q;
		run_len_d    = run_len_q;
		mark_bits_d  = mark_bits_q;
		mark_count_d = mark_count_q;
		mark_ovf_d   = mark_ovf_q;
		first_fail_d = first_fail_q;
		push.v0      = 1'b0;
		push.v1      = 1'b0;
		push.r0      = letter_res;
		push.r1      = '{kind: KIND_SPACE, code: '0, last: 1'b1};
		if (valid_s1) begin
			if (level == run_level_q) begin
				if (run_len_q != RUN_MAX) begin
					run_len_d = run_len_q + RUN_COUNT_WIDTH'(1);
				end
			end else begin
				run_level_d = level;
				run_len_d   = RUN_COUNT_WIDTH'(1);
				if (run_level_q) begin
					// bright run ended: append a mark
					if (mark_count_q < MARKS_MAX) begin
						mark_bits_d[mark_count_q] = is_long;
						mark_count_d = mark_count_q + SLEN_W'(1);
					end else begin
						mark_ovf_d = 1'b1;
					end
				end else if (letter_end) begin
					// dark gap ended the letter
					if (!letter_emit) begin
						first_fail_d = 1'b0;
					end
					mark_bits_d  = '0;
					mark_count_d = '0;
					mark_ovf_d   = 1'b0;
					if (letter_emit) begin
						push.v0 = 1'b1;
						push.v1 = word_end;
					end else begin
						push.v0 = word_end;
						push.r0 = push.r1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_level_q  <= 1'b0;
			run_len_q    <= '0;
			mark_bits_q  <= '0;
			mark_count_q <= '0;
			mark_ovf_q   <= 1'b0;
			first_fail_q <= 1'b1;
		end else begin
			run_level_q  <= run_level_d;
			run_len_q    <= run_len_d;
			mark_bits_q  <= mark_bits_d;
			mark_count_q <= mark_count_d;
			mark_ovf_q   <= mark_ovf_d;
			first_fail_q <= first_fail_d;
		end
	end

endmodule

@@ design/mld_result_fifo.sv @@
// mld_result_fifo: small result queue, two writes and one read per cycle
// depends on mld_pkg
module mld_result_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mld_pkg::push_t                 push,
	input  logic                           pop,
	output logic                           not_empty,
	output mld_pkg::res_t                  head,
	output logic [mld_pkg::FIFO_LVL_W-1:0] level
);
	import mld_pkg::*;

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_LVL_W-1:0] level_q;
	logic [FIFO_LVL_W-1:0] n_push;
	logic                  do_pop;

	assign not_empty = level_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign level     = level_q;
	assign do_pop    = pop && not_empty;
	assign n_push    = FIFO_LVL_W'(push.v0) + FIFO_LVL_W'(push.v1);

	// entry storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(do_pop);
			level_q  <= level_q + n_push - FIFO_LVL_W'(do_pop);
		end
	end

endmodule

@@ design/morse_light_decoder.sv @@
// morse_light_decoder: top level of the morse light decoder
// depends on mld_pkg, mld_cfg_regs, mld_decode, mld_result_fifo
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    light_sample
//  out       source     out_valid / out_ready  result_kind, char_code, last_of_run
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample request per cycle while in_ready is high; an accepted sample is registered
// in the input register, its results are computed from there and written into the output
// queue, and the first result is offered from the queue
// in_ready drops while the queue level plus two for a sample in flight is above
// two: under a stalled output side, and while a sample is in flight behind queued results
// asynchronous active-low reset clears run, mark and queue state; no clearing pass
module morse_light_decoder #(
	parameter int unsigned RUN_COUNT_WIDTH = mld_pkg::RUN_COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mld_pkg::SAMPLE_W-1:0]   light_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     result_kind,
	output logic [mld_pkg::CODE_W-1:0]     char_code,
	output logic                           last_of_run,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mld_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mld_pkg::*;

	cfg_t                  cfg;
	push_t                 push;
	res_t                  head;
	logic                  busy;
	logic [FIFO_LVL_W-1:0] level;
	logic [FIFO_LVL_W:0]   reserved;

	// queue room for the sample in flight and the new one
	assign reserved = (FIFO_LVL_W + 1)'(level) + (busy ? (FIFO_LVL_W + 1)'(2) : '0);
	assign in_ready = reserved <= (FIFO_LVL_W + 1)'(FIFO_DEPTH - 2);

	mld_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mld_decode #(
		.RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_valid && in_ready),
		.sample (light_sample),
		.cfg    (cfg),
		.busy   (busy),
		.push   (push)
	);

	mld_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_ready),
		.not_empty (out_valid),
		.head      (head),
		.level     (level)
	);

	// result fields
	assign result_kind = head.kind;
	assign char_code   = head.code;
	assign last_of_run = head.last;

endmodule

@@ design/mld_checker.sv @@
// mld_checker: port-level checks of the morse light decoder, bound to the top level
// depends on mld_pkg and morse_light_decoder
module mld_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   result_kind,
	input logic [mld_pkg::CODE_W-1:0]   char_code,
	input logic                         last_of_run
);
	import mld_pkg::*;

	// a stalled result request holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(char_code) && $stable(last_of_run))
		else $error("result changed while stalled");

	// only character results carry a code
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_CHAR |-> char_code == '0)
		else $error("non-character result with nonzero code");

	// character codes are lower-case letters or digits
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_CHAR |->
		(char_code >= ASCII_LOWER_A && char_code <= ASCII_LOWER_A + 7'd25) ||
		(char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + 7'd9))
		else $error("character code out of range");

	// a space always closes the results of its sample
	a_space_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_SPACE |-> last_of_run)
		else $error("space result not marked last");

endmodule

bind morse_light_decoder mld_checker u_mld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_kind (result_kind),
	.char_code   (char_code),
	.last_of_run (last_of_run)
);

@@ tb/sv/morse_light_decoder_test.sv @@
`timescale 1ns / 1ps
// morse_light_decoder_test: self-checking bench for the morse light decoder, with a directed
// table, random letter streams and an internal decoder model; depends on mld_pkg and the rtl
module morse_light_decoder_test;
	import mld_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 9;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;

	localparam int RUN_W = RUN_COUNT_WIDTH_DEF;
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
	localparam int MARK_LIMIT    = 5;
	localparam int TABLE_LETTERS = 36;
	localparam int DIGIT_FIRST   = 26;
	localparam int NEWLINE_ENTRY = 36;
	localparam logic [CODE_W-1:0] CHAR_A    = 7'd97;
	localparam logic [CODE_W-1:0] CHAR_ZERO = 7'd48;

	// register indexes past the six real registers
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	// directed table: sample, whether the results are written out here, and those results
	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic                typed;
		logic [1:0]          cnt;
		res_t                r0;
		res_t                r1;
	} probe_row_t;

	localparam res_t NO_RES = '{KIND_CHAR, 7'd0, 1'b0};
	localparam int PROBE_ROWS = 32;
	// threshold 100, long mark above 1, letter gap above 1, word gap above 2, newline ..--
	localparam probe_row_t PROBE [PROBE_ROWS] = '{
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd100,   1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		// empty letter fails quietly as the first failure, word gap still gives a space
		'{16'd101,   1'b1, 2'd1, '{KIND_SPACE, 7'd0, 1'b1}, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd101,   1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd101,   1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd40000, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		// ..-- is no stock letter, so it hits the newline entry
		'{16'd101,   1'b1, 2'd1, '{KIND_NEWLINE, 7'd0, 1'b1}, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd65535, 1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		// six short marks overflow the letter
		'{16'd101,   1'b1, 2'd2, '{KIND_WRONG, 7'd0, 1'b0}, '{KIND_SPACE, 7'd0, 1'b1}},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		'{16'd0,     1'b0, 2'd0, NO_RES, NO_RES},
		// single short mark is 'e'
		'{16'd101,   1'b1, 2'd1, '{KIND_CHAR, 7'd101, 1'b1}, NO_RES}
	};

	// dot and dash spelling of a-z then 0-9
	string morse_codes [TABLE_LETTERS] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----."
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   light_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [1:0]            result_kind;
	logic [CODE_W-1:0]     char_code;
	logic                  last_of_run;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// decoder model: registers and run state
	logic [THRESH_W-1:0] cur_thresh;
	logic [LEN_W-1:0]    cur_long;
	logic [LEN_W-1:0]    cur_letter;
	logic [LEN_W-1:0]    cur_word;
	logic [PAT_W-1:0]    cur_spec_pat;
	logic [SLEN_W-1:0]   cur_spec_len;
	logic                run_lvl;
	logic [RUN_W-1:0]    run_len;
	logic [PAT_W-1:0]    mark_bits;
	logic [SLEN_W-1:0]   mark_cnt;
	logic                mark_ovf;
	logic                fail_armed;

	res_t pending_results [$];
	int   mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int   samples_sent = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   hold_req = 1'b0;
	int   hold_left = 0;

	// typed expectations of the directed row being offered
	bit   row_typed = 1'b0;
	int   row_cnt = 0;
	res_t row_res [2];

	morse_light_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.light_sample (light_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.char_code    (char_code),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// exact match of the collected marks, first stock entry wins, then the newline entry
	function automatic int lookup_letter();
		string code;
		bit    same;
		int    mask;
		if (mark_ovf) return -1;
		for (int j = 0; j < TABLE_LETTERS; j++) begin
			code = morse_codes[j];
			if (code.len() == int'(mark_cnt)) begin
				same = 1'b1;
				for (int k = 0; k < code.len(); k++)
					if ((code.getc(k) == "-") != mark_bits[k]) same = 1'b0;
				if (same) return j;
			end
		end
		mask = (1 << mark_cnt) - 1;
		if (cur_spec_len == mark_cnt && ((int'(cur_spec_pat ^ mark_bits) & mask) == 0))
			return NEWLINE_ENTRY;
		return -1;
	endfunction

	// advance the model by one sample, returning the results it causes
	function automatic int decode_sample(input logic [SAMPLE_W-1:0] smp, output res_t got [2]);
		logic lvl;
		logic word_end;
		logic letter_end;
		int   entry;
		int   n;
		n = 0;
		got[0] = NO_RES;
		got[1] = NO_RES;
		lvl = (smp > cur_thresh);
		if (lvl == run_lvl) begin
			if (run_len != RUN_MAX) run_len++;
			return 0;
		end
		if (run_lvl) begin
			// bright run ended: one more mark
			if (mark_cnt < MARK_LIMIT) begin
				mark_bits[mark_cnt] = (run_len > cur_long);
				mark_cnt++;
			end else begin
				mark_ovf = 1'b1;
			end
		end else begin
			// dark run ended: maybe the letter and the word
			word_end = (run_len > cur_word);
			letter_end = word_end || (run_len > cur_letter);
			if (letter_end) begin
				entry = lookup_letter();
				if (entry < 0) begin
					if (fail_armed) begin
						fail_armed = 1'b0;
					end else begin
						got[n] = '{KIND_WRONG, 7'd0, 1'b0};
						n++;
					end
				end else if (entry == NEWLINE_ENTRY) begin
					got[n] = '{KIND_NEWLINE, 7'd0, 1'b0};
					n++;
				end else if (entry >= DIGIT_FIRST) begin
					got[n] = '{KIND_CHAR, CHAR_ZERO + CODE_W'(entry - DIGIT_FIRST), 1'b0};
					n++;
				end else begin
					got[n] = '{KIND_CHAR, CHAR_A + CODE_W'(entry), 1'b0};
					n++;
				end
				if (word_end) begin
					got[n] = '{KIND_SPACE, 7'd0, 1'b0};
					n++;
				end
				mark_bits = '0;
				mark_cnt = '0;
				mark_ovf = 1'b0;
			end
		end
		if (n > 0) got[n-1].last = 1'b1;
		run_lvl = lvl;
		run_len = RUN_W'(1);
		return n;
	endfunction

	// acceptance monitor: register tracking, model update, result check, quiet-cycle watchdog
	always @(posedge clk) begin : monitor
		res_t fresh [2];
		int   n_fresh;
		res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with none pending: kind %0d code %0d", result_kind, char_code);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
						mismatch_count++;
					end
					if (char_code !== want.code) begin
						$error("char_code: expected %0d, got %0d", want.code, char_code);
						mismatch_count++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
						mismatch_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD:   cur_thresh = cfg_data[THRESH_W-1:0];
					REG_LONG_MARK:   cur_long = cfg_data[LEN_W-1:0];
					REG_LETTER_GAP:  cur_letter = cfg_data[LEN_W-1:0];
					REG_WORD_GAP:    cur_word = cfg_data[LEN_W-1:0];
					REG_SPECIAL_PAT: cur_spec_pat = cfg_data[PAT_W-1:0];
					REG_SPECIAL_LEN: cur_spec_len = cfg_data[SLEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				n_fresh = decode_sample(light_sample, fresh);
				if (row_typed) begin
					for (int k = 0; k < row_cnt; k++) pending_results.push_back(row_res[k]);
				end else begin
					for (int k = 0; k < n_fresh; k++) pending_results.push_back(fresh[k]);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// one sample request, with random idle cycles ahead of it
	task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		light_sample <= smp;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		samples_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// all six registers, then a stray index that must be ignored
	task automatic program_regs(input logic [THRESH_W-1:0] thr, input logic [LEN_W-1:0] lng,
			input logic [LEN_W-1:0] ltr, input logic [LEN_W-1:0] wrd,
			input logic [PAT_W-1:0] pat, input logic [SLEN_W-1:0] slen);
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(REG_LONG_MARK, lng);
		write_reg(REG_LETTER_GAP, ltr);
		write_reg(REG_WORD_GAP, wrd);
		write_reg(REG_SPECIAL_PAT, CFG_DATA_W'(pat) | {1'($urandom_range(1, 0)), 23'd0});
		write_reg(REG_SPECIAL_LEN, CFG_DATA_W'(slen));
		write_reg($urandom_range(1, 0) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// stop offering and wait for every pending result plus the pipeline tail
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] level_value(input bit bright);
		if (bright && cur_thresh != 16'hFFFF)
			return SAMPLE_W'($urandom_range(65535, int'(cur_thresh) + 1));
		if (bright) return 16'hFFFF;
		return SAMPLE_W'($urandom_range(int'(cur_thresh), 0));
	endfunction

	task automatic send_run(input bit bright, input int len);
		for (int k = 0; k < len; k++) push_sample(level_value(bright));
	endtask

	// a letter: marks separated by short gaps, sometimes ragged ones, closed by a letter or word gap
	task automatic send_letter();
		int marks;
		int gap_cap;
		int r;
		bit ragged;
		r = $urandom_range(99, 0);
		if (r < 8) marks = $urandom_range(7, 6);
		else if (r < 11) marks = 0;
		else marks = $urandom_range(5, 1);
		ragged = ($urandom_range(9, 0) == 0);
		gap_cap = (cur_letter < cur_word) ? int'(cur_letter) : int'(cur_word);
		for (int k = 0; k < marks; k++) begin
			if ($urandom_range(1, 0)) send_run(1'b1, int'(cur_long) + $urandom_range(3, 1));
			else send_run(1'b1, $urandom_range(int'(cur_long), 1));
			if (k == marks - 1) break;
			send_run(1'b0, ragged ? $urandom_range(gap_cap + 2, 1) : $urandom_range(gap_cap, 1));
		end
		if (cur_letter < cur_word && $urandom_range(1, 0))
			send_run(1'b0, $urandom_range(int'(cur_word), int'(cur_letter) + 1));
		else
			send_run(1'b0, int'(cur_word) + $urandom_range(3, 1));
	endtask

	// random samples, a quarter of them at or just above the threshold
	task automatic send_noise();
		int cnt;
		logic [SAMPLE_W-1:0] v;
		cnt = $urandom_range(8, 1);
		for (int k = 0; k < cnt; k++) begin
			if ($urandom_range(3, 0) == 0)
				v = (cur_thresh == 16'hFFFF) ? cur_thresh : cur_thresh + SAMPLE_W'($urandom_range(1, 0));
			else
				v = SAMPLE_W'($urandom);
			push_sample(v);
		end
	endtask

	task automatic run_phase(input int n_items, input bit noise_only);
		int stop_at;
		stop_at = samples_sent + n_items;
		while (samples_sent < stop_at) begin
			if (noise_only || $urandom_range(9, 0) == 0) send_noise();
			else send_letter();
		end
	endtask

	// a newline pattern of four marks that no stock letter takes
	function automatic logic [PAT_W-1:0] free_four_marks();
		case ($urandom_range(3, 0))
			0: return 5'b01100;
			1: return 5'b01010;
			2: return 5'b00111;
			default: return 5'b01111;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		light_sample = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		// model state after reset
		cur_thresh = 16'd100;
		cur_long = 24'd1000;
		cur_letter = 24'd2000;
		cur_word = 24'd3000;
		cur_spec_pat = 5'd0;
		cur_spec_len = 3'd5;
		run_lvl = 1'b0;
		run_len = '0;
		mark_bits = '0;
		mark_cnt = '0;
		mark_ovf = 1'b0;
		fail_armed = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		program_regs(16'd100, 24'd1, 24'd1, 24'd2, 5'b01100, 3'd4);
		for (int i = 0; i < PROBE_ROWS; i++) begin
			row_typed = PROBE[i].typed;
			row_cnt = int'(PROBE[i].cnt);
			row_res[0] = PROBE[i].r0;
			row_res[1] = PROBE[i].r1;
			push_sample(PROBE[i].smp);
		end
		row_typed = 1'b0;
		settle();

		// no idling, five-mark newline
		program_regs(16'd100, 24'd2, 24'd3, 24'd6, PAT_W'($urandom), 3'd5);
		run_phase(500, 1'b0);
		settle();

		// sender mostly idle, four-mark newline
		send_idle_pct = 73;
		program_regs(16'h8000, 24'd1, 24'd2, 24'd4, free_four_marks(), 3'd4);
		run_phase(300, 1'b0);
		settle();

		// receiver mostly stalling, lowest threshold
		send_idle_pct = 0;
		recv_stall_pct = 73;
		program_regs(16'd0, 24'd3, 24'd4, 24'd5, PAT_W'($urandom), 3'd0);
		run_phase(300, 1'b0);
		settle();

		// top of every range: nothing is bright and no gap can end
		send_idle_pct = 22;
		recv_stall_pct = 0;
		program_regs(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 5'b11111, 3'd7);
		run_phase(60, 1'b1);
		settle();

		// word gap below letter gap, newline entry out of range, both sides idling
		recv_stall_pct = 22;
		program_regs(16'd1234, 24'd1, 24'd5, 24'd2, PAT_W'($urandom), 3'd6);
		run_phase(300, 1'b0);
		settle();

		// result side held off while samples keep coming, then a full drain mid-stream
		send_idle_pct = 0;
		recv_stall_pct = 0;
		program_regs(16'd300, 24'd1, 24'd1, 24'd1, PAT_W'($urandom), 3'd5);
		hold_req = 1'b1;
		run_phase(200, 1'b0);
		settle();
		run_phase(200, 1'b0);
		settle();

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
design/mld_pkg.sv
design/mld_cfg_regs.sv
design/mld_decode.sv
design/mld_result_fifo.sv
design/morse_light_decoder.sv
design/mld_checker.sv
tb/sv/morse_light_decoder_test.sv
